// ===== sv/b64c_pkg.sv =====
// Shared types, constants and functions of the framed base64 encoder with CRC-24 trailer.
package b64c_pkg;

    // Longest character run that one payload byte can cause.
    localparam int MAX_CHARS = 11;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);

    // OpenPGP CRC-24 constants.
    localparam logic [23:0] CRC_INIT = 24'hB704CE;
    localparam logic [23:0] CRC_POLY = 24'h864CFB;

    // Framing characters.
    localparam logic [7:0] CHAR_START = 8'h5E;  // '^'
    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_CRC   = 8'h3F;  // '?'
    localparam logic [7:0] CHAR_END   = 8'h24;  // '$'

    // One payload request.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } payload_t;

    // One output character.
    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } symbol_t;

    // Character run of one request, handed from the framer to the serializer.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [CNT_W-1:0]          cnt;
    } pend_t;

    // Maps a 6-bit value onto the standard base64 alphabet.
    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        logic [7:0] c;
        case (v) inside
            [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
            [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
            [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
            6'd62:         c = 8'h2B;
            default:       c = 8'h2F;
        endcase
        return c;
    endfunction

    // Advances the CRC-24 register by one byte, MSB first.
    function automatic logic [23:0] crc_step(input logic [23:0] crc, input logic [7:0] b);
        logic [23:0] c;
        c = crc ^ {b, 16'h0000};
        for (int i = 0; i < 8; i++) begin
            if (c[23]) begin
                c = {c[22:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                c = {c[22:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/b64c_framer.sv =====
// Input register, frame state and character-run builder of the base64 encoder.
module b64c_framer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               payload_valid,
    output logic               payload_ready,
    input  b64c_pkg::payload_t payload,
    output logic               pend_valid,
    input  logic               pend_take,
    output b64c_pkg::pend_t    pend
);
    import b64c_pkg::*;

    logic        in_valid_reg;
    payload_t    in_data_reg;
    logic [23:0] crc_reg;
    logic [23:0] crc_next;
    logic [15:0] held_bytes_reg;
    logic [15:0] held_bytes_next;
    logic [1:0]  held_count_reg;
    logic [1:0]  held_count_next;
    logic        in_frame_reg;
    logic        in_frame_next;
    logic        pend_valid_reg;
    pend_t       pend_reg;
    pend_t       pend_next;

    logic        advance;
    logic [23:0] crc_new;
    logic [1:0]  cnt;
    logic [23:0] grp;
    logic [2:0]  nsym;
    logic [1:0]  npad;
    logic [CNT_W-1:0] n;

    // The builder moves forward when the pending slot is free or being emptied.
    assign advance       = in_valid_reg && (!pend_valid_reg || pend_take);
    assign payload_ready = !in_valid_reg || advance;
    assign pend_valid    = pend_valid_reg;
    assign pend          = pend_reg;

    // Group formation and next frame state.
    always_comb
    begin
        cnt     = (held_count_reg == 2'd3) ? 2'd2 : held_count_reg;
        crc_new = crc_step(crc_reg, in_data_reg.data_byte);
        grp     = '0;
        nsym    = 3'd0;
        npad    = 2'd0;
        held_bytes_next = held_bytes_reg;
        held_count_next = cnt;
        if (cnt == 2'd2) begin
            grp             = {held_bytes_reg, in_data_reg.data_byte};
            nsym            = 3'd4;
            held_bytes_next = '0;
            held_count_next = 2'd0;
        end
        else begin
            held_bytes_next = {held_bytes_reg[7:0], in_data_reg.data_byte};
            held_count_next = cnt + 2'd1;
            if (in_data_reg.last) begin
                if (cnt == 2'd0) begin
                    grp  = {in_data_reg.data_byte, 16'h0000};
                    nsym = 3'd2;
                    npad = 2'd2;
                end
                else begin
                    grp  = {held_bytes_reg[7:0], in_data_reg.data_byte, 8'h00};
                    nsym = 3'd3;
                    npad = 2'd1;
                end
            end
        end
        if (in_data_reg.last) begin
            crc_next        = CRC_INIT;
            held_bytes_next = '0;
            held_count_next = 2'd0;
            in_frame_next   = 1'b0;
        end
        else begin
            crc_next      = crc_new;
            in_frame_next = 1'b1;
        end
    end

    // Lay out the characters of this request in order.
    always_comb
    begin
        pend_next = '0;
        n         = '0;
        if (!in_frame_reg) begin
            pend_next.chars[n] = CHAR_START;
            n = n + 1'b1;
        end
        for (int k = 0; k < 4; k++) begin
            if (3'(k) < nsym) begin
                pend_next.chars[n] = b64_symbol(grp[23 - 6 * k -: 6]);
                n = n + 1'b1;
            end
        end
        for (int k = 0; k < 2; k++) begin
            if (2'(k) < npad) begin
                pend_next.chars[n] = CHAR_PAD;
                n = n + 1'b1;
            end
        end
        if (in_data_reg.last) begin
            pend_next.chars[n] = CHAR_CRC;
            n = n + 1'b1;
            for (int k = 0; k < 4; k++) begin
                pend_next.chars[n] = b64_symbol(crc_new[23 - 6 * k -: 6]);
                n = n + 1'b1;
            end
            pend_next.chars[n] = CHAR_END;
            n = n + 1'b1;
        end
        pend_next.cnt = n;
    end

    // Control and frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            crc_reg        <= CRC_INIT;
            held_bytes_reg <= '0;
            held_count_reg <= '0;
            in_frame_reg   <= 1'b0;
        end
        else begin
            if (payload_ready) begin
                in_valid_reg <= payload_valid;
            end
            if (advance) begin
                // A request that yields no character never occupies the slot.
                pend_valid_reg <= (pend_next.cnt != '0);
                crc_reg        <= crc_next;
                held_bytes_reg <= held_bytes_next;
                held_count_reg <= held_count_next;
                in_frame_reg   <= in_frame_next;
            end
            else if (pend_take) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (payload_ready && payload_valid) begin
            in_data_reg <= payload;
        end
        if (advance) begin
            pend_reg <= pend_next;
        end
    end

endmodule

// ===== sv/b64c_serializer.sv =====
// Output shift register that sends one character run, a character per cycle while symbol_ready is high.
module b64c_serializer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pend_valid,
    output logic              pend_take,
    input  b64c_pkg::pend_t   pend,
    output logic              symbol_valid,
    input  logic              symbol_ready,
    output b64c_pkg::symbol_t symbol
);
    import b64c_pkg::*;

    logic [MAX_CHARS-1:0][7:0] buf_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      fire;
    logic                      can_load;

    assign symbol_valid    = (cnt_reg != '0);
    assign symbol.out_char = buf_reg[0];
    assign symbol.run_last = (cnt_reg == CNT_W'(1));
    assign fire            = symbol_valid && symbol_ready;
    assign can_load        = !symbol_valid || (fire && symbol.run_last);
    assign pend_take       = pend_valid && can_load;

    // Character count of the run being sent.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end
        else if (pend_take) begin
            cnt_reg <= pend.cnt;
        end
        else if (fire) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Character shift register, oldest character at the bottom.
    always_ff @(posedge clk)
    begin
        if (pend_take) begin
            buf_reg <= pend.chars;
        end
        else if (fire) begin
            buf_reg <= {8'h00, buf_reg[MAX_CHARS-1:1]};
        end
    end

endmodule

// ===== sv/base64_crc24_frame_encoder.sv =====
// Top level of the framed base64 encoder with OpenPGP CRC-24 trailer.
//
// Payload bytes enter one per request on the payload channel (valid/ready),
// with last marking the final byte of a frame. Characters leave one per
// request on the symbol channel: '^' opens a frame, every 3 bytes give 4
// base64 symbols, and the last byte closes any partial group with '='
// padding, then sends '?', four symbols of the CRC-24 and '$'.
// run_last is set on the final character caused by one payload byte.
// The first character of a byte passes the input register, then the run
// register and the output shifter before it shows.
// A byte is taken every cycle while the two stage registers have room;
// the symbol channel sends one character per cycle while symbol_ready is
// high, so the sustained rate is set by the output shifter, which sends
// 4 characters per 3 bytes mid-frame and up to 11 for a frame's last byte.
// Reset clears the frame state and empties all stages. A stall on the
// symbol channel holds the current character; up to two further bytes
// are buffered before payload_ready drops.
module base64_crc24_frame_encoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               payload_valid,
    output logic               payload_ready,
    input  b64c_pkg::payload_t payload,
    output logic               symbol_valid,
    input  logic               symbol_ready,
    output b64c_pkg::symbol_t  symbol
);
    import b64c_pkg::*;

    logic  pend_valid;
    logic  pend_take;
    pend_t pend;

    // Frame state and character-run builder.
    b64c_framer u_framer (
        .clk           (clk),
        .rst_n         (rst_n),
        .payload_valid (payload_valid),
        .payload_ready (payload_ready),
        .payload       (payload),
        .pend_valid    (pend_valid),
        .pend_take     (pend_take),
        .pend          (pend)
    );

    // Character-per-cycle output while symbol_ready is high.
    b64c_serializer u_serializer (
        .clk          (clk),
        .rst_n        (rst_n),
        .pend_valid   (pend_valid),
        .pend_take    (pend_take),
        .pend         (pend),
        .symbol_valid (symbol_valid),
        .symbol_ready (symbol_ready),
        .symbol       (symbol)
    );

    // A pending run is never empty and never longer than the longest run.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid |-> (pend.cnt != '0) && (pend.cnt <= CNT_W'(MAX_CHARS)))
        else $error("pending run has an illegal length");

    // A pending run that the serializer does not take stays unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid && !pend_take |=> pend_valid && $stable(pend))
        else $error("pending run changed while waiting");

    // The frame end character is always the last one of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid && (symbol.out_char == CHAR_END) |-> symbol.run_last)
        else $error("frame end character not flagged as last of run");

endmodule
